// ===== design/adam_pkg.sv =====
`timescale 1ns / 1ps
// Package for the Adam update pipeline: field widths, payload structs and CSR indexes.
// Used by the top level and the testbench; depends on nothing.
package adam_pkg;

   // Field widths of one beat
   localparam int VALUE_BITS = 48;
   localparam int COUNT_BITS = 20;

   // Fraction bits of the Q formats
   localparam int FRAC_BITS = 32;

   // CSR indexes
   localparam logic [1:0] CSR_STEP_SIZE    = 2'd0;
   localparam logic [1:0] CSR_DECAY_FIRST  = 2'd1;
   localparam logic [1:0] CSR_DECAY_SECOND = 2'd2;
   localparam logic [1:0] CSR_EPSILON      = 2'd3;

   // CSR reset values
   localparam logic [31:0] STEP_SIZE_RST    = 32'd4294967;
   localparam logic [31:0] DECAY_FIRST_RST  = 32'd3865470566;
   localparam logic [31:0] DECAY_SECOND_RST = 32'd4290672329;
   localparam logic [31:0] EPSILON_RST      = 32'd43;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] weight_value;
      logic signed [VALUE_BITS-1:0] gradient_value;
      logic signed [VALUE_BITS-1:0] first_moment;
      logic        [VALUE_BITS-1:0] second_moment;
      logic        [COUNT_BITS-1:0] update_count;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] new_weight;
      logic signed [VALUE_BITS-1:0] new_first_moment;
      logic        [VALUE_BITS-1:0] new_second_moment;
   } rsp_type;

endpackage

// ===== design/adam_delay.sv =====
`timescale 1ns / 1ps
// Payload delay line with a shared advance enable.
// No package dependency.
module adam_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   generate
      if (DEPTH == 0) begin : g_none
         assign dout = din;
      end else begin : g_line
         logic [WIDTH-1:0] tap_ff [DEPTH];

         // shift one tap per advance
         always_ff @(posedge clock) begin
            if (en) begin
               tap_ff[0] <= din;
               for (int i = 1; i < DEPTH; i++) begin
                  tap_ff[i] <= tap_ff[i-1];
               end
            end
         end

         assign dout = tap_ff[DEPTH-1];
      end
   endgenerate

endmodule

// ===== design/adam_pow.sv =====
`timescale 1ns / 1ps
// Pipelined square-and-multiply power of a Q0.32 base, one exponent bit per stage.
// Result is Q1.32 (2^32 means one). No package dependency.
module adam_pow #(
   parameter int EXP_BITS = 21
) (
   input  logic                clock,
   input  logic                en,
   input  logic [EXP_BITS-1:0] exp_in,
   input  logic [31:0]         base_in,
   output logic [32:0]         pow_out
);

   logic [32:0]         p_ff [EXP_BITS];
   logic [31:0]         b_ff [EXP_BITS];
   logic [EXP_BITS-1:0] e_ff [EXP_BITS];

   generate
      for (genvar j = 0; j < EXP_BITS; j++) begin : g_stage
         logic [32:0]         p_cur;
         logic [31:0]         b_cur;
         logic [EXP_BITS-1:0] e_cur;
         logic [63:0]         pb_prod;
         logic [63:0]         bb_prod;
         logic [32:0]         p_mul;
         logic [32:0]         p_in;
         logic [31:0]         b_in;

         if (j == 0) begin : g_first
            assign p_cur = 33'h1_0000_0000;
            assign b_cur = base_in;
            assign e_cur = exp_in;
         end else begin : g_next
            assign p_cur = p_ff[j-1];
            assign b_cur = b_ff[j-1];
            assign e_cur = e_ff[j-1];
         end

         // multiply by the base when this exponent bit is set, then square the base
         always_comb begin
            pb_prod = p_cur[31:0] * b_cur;
            bb_prod = b_cur * b_cur;
            p_mul   = p_cur[32] ? {1'b0, b_cur} : {1'b0, pb_prod[63:32]};
            p_in    = e_cur[0] ? p_mul : p_cur;
            b_in    = bb_prod[63:32];
         end

         always_ff @(posedge clock) begin
            if (en) begin
               p_ff[j] <= p_in;
               b_ff[j] <= b_in;
               e_ff[j] <= e_cur >> 1;
            end
         end
      end
   endgenerate

   assign pow_out = p_ff[EXP_BITS-1];

endmodule

// ===== design/adam_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage (restoring method).
// Floor of the root of a 2*ROOT_BITS radicand. No package dependency.
module adam_sqrt #(
   parameter int ROOT_BITS = 33
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [2*ROOT_BITS-1:0] rad_in,
   output logic [ROOT_BITS-1:0]   root_out
);

   logic [ROOT_BITS+1:0]   rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0]   root_ff [ROOT_BITS];
   logic [2*ROOT_BITS-1:0] rad_ff  [ROOT_BITS];

   generate
      for (genvar j = 0; j < ROOT_BITS; j++) begin : g_stage
         logic [ROOT_BITS+1:0]   rem_cur;
         logic [ROOT_BITS-1:0]   root_cur;
         logic [2*ROOT_BITS-1:0] rad_cur;
         logic [ROOT_BITS+2:0]   shifted;
         logic [ROOT_BITS+2:0]   trial;
         logic [ROOT_BITS+2:0]   diff;
         logic                   ge;

         if (j == 0) begin : g_first
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign rad_cur  = rad_in;
         end else begin : g_next
            assign rem_cur  = rem_ff[j-1];
            assign root_cur = root_ff[j-1];
            assign rad_cur  = rad_ff[j-1];
         end

         // bring down two radicand bits, try root*4+1
         always_comb begin
            shifted = {rem_cur[ROOT_BITS:0], rad_cur[2*ROOT_BITS-1 -: 2]};
            trial   = {1'b0, root_cur, 2'b01};
            ge      = (shifted >= trial);
            diff    = shifted - trial;
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j]  <= ge ? diff[ROOT_BITS+1:0] : shifted[ROOT_BITS+1:0];
               root_ff[j] <= {root_cur[ROOT_BITS-2:0], ge};
               rad_ff[j]  <= rad_cur << 2;
            end
         end
      end
   endgenerate

   assign root_out = root_ff[ROOT_BITS-1];

endmodule

// ===== design/adam_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// floor({hi,lo}/d), all ones when the quotient overflows. No package dependency.
module adam_div #(
   parameter int QUO_BITS = 64,
   parameter int DIV_BITS = 64
) (
   input  logic                clock,
   input  logic                en,
   input  logic [DIV_BITS-1:0] hi_in,
   input  logic [QUO_BITS-1:0] lo_in,
   input  logic [DIV_BITS-1:0] den_in,
   output logic [QUO_BITS-1:0] quo_out
);

   logic [DIV_BITS-1:0] r_ff   [QUO_BITS];
   logic [QUO_BITS-1:0] q_ff   [QUO_BITS];
   logic [QUO_BITS-1:0] lo_ff  [QUO_BITS];
   logic [DIV_BITS-1:0] d_ff   [QUO_BITS];
   logic                sat_ff [QUO_BITS];

   generate
      for (genvar j = 0; j < QUO_BITS; j++) begin : g_stage
         logic [DIV_BITS-1:0] r_cur;
         logic [QUO_BITS-1:0] q_cur;
         logic [QUO_BITS-1:0] lo_cur;
         logic [DIV_BITS-1:0] d_cur;
         logic                sat_cur;
         logic [DIV_BITS:0]   part;
         logic [DIV_BITS:0]   diff;
         logic                ge;

         if (j == 0) begin : g_first
            assign r_cur   = hi_in;
            assign q_cur   = '0;
            assign lo_cur  = lo_in;
            assign d_cur   = den_in;
            assign sat_cur = (hi_in >= den_in);
         end else begin : g_next
            assign r_cur   = r_ff[j-1];
            assign q_cur   = q_ff[j-1];
            assign lo_cur  = lo_ff[j-1];
            assign d_cur   = d_ff[j-1];
            assign sat_cur = sat_ff[j-1];
         end

         // shift in the next dividend bit and subtract when it fits
         always_comb begin
            part = {r_cur, lo_cur[QUO_BITS-1]};
            ge   = (part >= {1'b0, d_cur});
            diff = part - {1'b0, d_cur};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               r_ff[j]   <= ge ? diff[DIV_BITS-1:0] : part[DIV_BITS-1:0];
               q_ff[j]   <= {q_cur[QUO_BITS-2:0], ge};
               lo_ff[j]  <= lo_cur << 1;
               d_ff[j]   <= d_cur;
               sat_ff[j] <= sat_cur;
            end
         end
      end
   endgenerate

   assign quo_out = sat_ff[QUO_BITS-1] ? '1 : q_ff[QUO_BITS-1];

endmodule

// ===== design/adam_optimizer_update.sv =====
`timescale 1ns / 1ps
// Top level of the elementwise Adam update pipeline.
// Uses adam_pkg, adam_delay, adam_pow, adam_sqrt and adam_div.
//
// Usage:
//   req_* carries one weight element per beat (weight, gradient, both moments,
//   update count); rsp_* returns the new weight and the new moments.
//   csr_* is a write-only register port (step size, two decays, epsilon);
//   write it only while the pipeline is empty.
//   Fully pipelined: one beat accepted per cycle while the output is not stalled.
//   The pipeline depth is set by the bias correction path: 21 power stages,
//   a 33-stage root, a 64-stage divider, plus product and update stages.
//   Stall: the whole pipeline advances as one; when rsp_valid is high and
//   rsp_ready is low every stage holds and req_ready drops. Nothing is lost.
//   Reset (synchronous, active high) empties the pipeline and restores the
//   default register values.
module adam_optimizer_update (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  adam_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output adam_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import adam_pkg::*;

   localparam int VB  = VALUE_BITS;
   localparam int TB  = COUNT_BITS + 1;
   localparam int RB  = (VB + FRAC_BITS + 1) / 2;
   localparam int RB2 = FRAC_BITS + 1;
   localparam int QB  = 64;
   localparam int TR  = 3 + TB + RB2 + QB;
   localparam int TQ  = 7 + RB + QB;
   localparam int TA  = (TR > TQ) ? TR : TQ;
   localparam int NST = TA + 4;

   localparam logic signed [66:0] MN_MAX = (67'sd1 <<< (VB - 1)) - 67'sd1;
   localparam logic signed [66:0] MN_MIN = -(67'sd1 <<< (VB - 1));
   localparam logic signed [65:0] W_TOP  = (66'sd1 <<< (VB - 1)) - 66'sd1;
   localparam logic signed [65:0] W_BOT  = -(66'sd1 <<< (VB - 1));
   localparam logic [VB-1:0]      V_MAX  = '1;
   localparam logic [32:0]        ONE_Q  = 33'h1_0000_0000;

   // control and CSRs
   logic [31:0]    step_ff, b1_ff, b2_ff, eps_ff;
   logic [NST-1:0] vld_ff;
   logic           adv;

   assign adv       = !vld_ff[NST-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[NST-1];

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_SIZE_RST;
         b1_ff   <= DECAY_FIRST_RST;
         b2_ff   <= DECAY_SECOND_RST;
         eps_ff  <= EPSILON_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STEP_SIZE:    step_ff <= csr_wdata;
            CSR_DECAY_FIRST:  b1_ff   <= csr_wdata;
            CSR_DECAY_SECOND: b2_ff   <= csr_wdata;
            CSR_EPSILON:      eps_ff  <= csr_wdata;
            default:          step_ff <= step_ff;
         endcase
      end
   end

   // valid bits travel with the beat
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   // stage 0: input register
   req_type in_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff <= req_data;
      end
   end

   // stage 1: magnitudes, count + 1
   logic          g_neg1_ff, m_neg1_ff;
   logic [63:0]   g_mag1_ff, m_mag1_ff, v1_ff;
   logic [TB-1:0] t1_ff;
   logic [63:0]   g_sx, m_sx;

   always_comb begin
      g_sx = 64'(in_ff.gradient_value);
      m_sx = 64'(in_ff.first_moment);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_neg1_ff <= in_ff.gradient_value[VB-1];
         m_neg1_ff <= in_ff.first_moment[VB-1];
         g_mag1_ff <= in_ff.gradient_value[VB-1] ? (64'd0 - g_sx) : g_sx;
         m_mag1_ff <= in_ff.first_moment[VB-1] ? (64'd0 - m_sx) : m_sx;
         v1_ff     <= 64'(in_ff.second_moment);
         t1_ff     <= TB'(in_ff.update_count) + TB'(1);
      end
   end

   // stage 2: partial products for the moments
   logic [63:0] pm_hi_ff, pm_lo_ff, gg_ll_ff, gg_lh_ff, gg_hh_ff, pv_hi_ff, pv_lo_ff;
   logic [64:0] pg_hi_ff, pg_lo_ff;
   logic        g_neg2_ff, m_neg2_ff;
   logic [32:0] c1;
   logic [64:0] pg_hi_in, pg_lo_in;

   always_comb begin
      c1       = ONE_Q - {1'b0, b1_ff};
      pg_hi_in = g_mag1_ff[63:32] * c1;
      pg_lo_in = g_mag1_ff[31:0] * c1;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pm_hi_ff  <= m_mag1_ff[63:32] * b1_ff;
         pm_lo_ff  <= m_mag1_ff[31:0] * b1_ff;
         pg_hi_ff  <= pg_hi_in;
         pg_lo_ff  <= pg_lo_in;
         gg_ll_ff  <= g_mag1_ff[31:0] * g_mag1_ff[31:0];
         gg_lh_ff  <= g_mag1_ff[31:0] * g_mag1_ff[63:32];
         gg_hh_ff  <= g_mag1_ff[63:32] * g_mag1_ff[63:32];
         pv_hi_ff  <= v1_ff[63:32] * b2_ff;
         pv_lo_ff  <= v1_ff[31:0] * b2_ff;
         g_neg2_ff <= g_neg1_ff;
         m_neg2_ff <= m_neg1_ff;
      end
   end

   // stage 3: floored signed terms, g^2, b2*v
   logic signed [65:0] mterm3_ff, gterm3_ff;
   logic [63:0]        g2_3_ff, v1_3_ff;
   logic [64:0]        m_r, g_r;
   logic [65:0]        m_up, g_up;
   logic [127:0]       gsq;

   always_comb begin
      m_r  = {1'b0, pm_hi_ff} + 65'(pm_lo_ff[63:32]);
      g_r  = pg_hi_ff + 65'(pg_lo_ff[64:32]);
      m_up = {2'b0, m_r[63:0]} + 66'(pm_lo_ff[31:0] != 32'd0);
      g_up = {2'b0, g_r[63:0]} + 66'(pg_lo_ff[31:0] != 32'd0);
      gsq  = 128'(gg_ll_ff) + (128'(gg_lh_ff) << 33) + (128'(gg_hh_ff) << 64);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mterm3_ff <= m_neg2_ff ? -$signed(m_up) : $signed({2'b0, m_r[63:0]});
         gterm3_ff <= g_neg2_ff ? -$signed(g_up) : $signed({2'b0, g_r[63:0]});
         g2_3_ff   <= (gsq[127:96] != 32'd0) ? '1 : gsq[95:32];
         v1_3_ff   <= pv_hi_ff + 64'(pv_lo_ff[63:32]);
      end
   end

   // stage 4: new first moment, (1-b2)*g^2 partials
   logic signed [VB-1:0] mn4_ff;
   logic [64:0]          gq_hi_ff, gq_lo_ff;
   logic [63:0]          v1_4_ff;
   logic signed [66:0]   msum;
   logic [32:0]          c2;
   logic [64:0]          gq_hi_in, gq_lo_in;

   always_comb begin
      msum     = 67'(mterm3_ff) + 67'(gterm3_ff);
      c2       = ONE_Q - {1'b0, b2_ff};
      gq_hi_in = g2_3_ff[63:32] * c2;
      gq_lo_in = g2_3_ff[31:0] * c2;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         priority if (msum > MN_MAX) begin
            mn4_ff <= MN_MAX[VB-1:0];
         end else if (msum < MN_MIN) begin
            mn4_ff <= MN_MIN[VB-1:0];
         end else begin
            mn4_ff <= msum[VB-1:0];
         end
         gq_hi_ff <= gq_hi_in;
         gq_lo_ff <= gq_lo_in;
         v1_4_ff  <= v1_3_ff;
      end
   end

   // stage 5: second product term, |m'|
   logic [63:0] v2_5_ff, v1_5_ff, m_mag5_ff;
   logic [64:0] v2_sum;
   logic [63:0] mn_sx;

   always_comb begin
      v2_sum = gq_hi_ff + 65'(gq_lo_ff[64:32]);
      mn_sx  = 64'(mn4_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v2_5_ff   <= v2_sum[63:0];
         v1_5_ff   <= v1_4_ff;
         m_mag5_ff <= mn4_ff[VB-1] ? (64'd0 - mn_sx) : mn_sx;
      end
   end

   // stage 6: new second moment, saturated
   logic [VB-1:0] vn6_ff;
   logic [64:0]   vsum;

   assign vsum = {1'b0, v1_5_ff} + {1'b0, v2_5_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         vn6_ff <= (vsum > 65'(V_MAX)) ? V_MAX : vsum[VB-1:0];
      end
   end

   // root of v' in Q.32, then the denominator
   logic [RB-1:0] vroot;
   logic [63:0]   den_ff, den_sum;
   logic [63:0]   m_mag_d;

   adam_sqrt #(.ROOT_BITS(RB)) u_vroot (
      .clock    (clock),
      .en       (adv),
      .rad_in   ((2*RB)'({vn6_ff, 32'd0})),
      .root_out (vroot)
   );

   assign den_sum = 64'(vroot) + 64'(eps_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff <= (den_sum == 64'd0) ? 64'd1 : den_sum;
      end
   end

   adam_delay #(.WIDTH(64), .DEPTH(RB + 2)) u_mmag_dly (
      .clock (clock),
      .en    (adv),
      .din   (m_mag5_ff),
      .dout  (m_mag_d)
   );

   // |m'| * 2^32 / den
   logic [63:0] quo, quo_a;

   adam_div #(.QUO_BITS(QB), .DIV_BITS(64)) u_qdiv (
      .clock   (clock),
      .en      (adv),
      .hi_in   (m_mag_d >> 32),
      .lo_in   ({m_mag_d[31:0], 32'd0}),
      .den_in  (den_ff),
      .quo_out (quo)
   );

   adam_delay #(.WIDTH(64), .DEPTH(TA - TQ)) u_quo_dly (
      .clock (clock),
      .en    (adv),
      .din   (quo),
      .dout  (quo_a)
   );

   // bias correction: b1^t and b2^t
   logic [32:0] p1, p2;
   logic [32:0] d1_ff, d2_ff, d1_r, d1_p_ff;

   adam_pow #(.EXP_BITS(TB)) u_pow1 (
      .clock   (clock),
      .en      (adv),
      .exp_in  (t1_ff),
      .base_in (b1_ff),
      .pow_out (p1)
   );

   adam_pow #(.EXP_BITS(TB)) u_pow2 (
      .clock   (clock),
      .en      (adv),
      .exp_in  (t1_ff),
      .base_in (b2_ff),
      .pow_out (p2)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff <= ONE_Q - p1;
         d2_ff <= ONE_Q - p2;
      end
   end

   // sqrt(1 - b2^t) in Q1.32
   logic [RB2-1:0] r2;

   adam_sqrt #(.ROOT_BITS(RB2)) u_croot (
      .clock    (clock),
      .en       (adv),
      .rad_in   ((2*RB2)'({d2_ff, 32'd0})),
      .root_out (r2)
   );

   adam_delay #(.WIDTH(33), .DEPTH(RB2)) u_d1_dly (
      .clock (clock),
      .en    (adv),
      .din   (d1_ff),
      .dout  (d1_r)
   );

   // step * root, then divide by 1 - b1^t
   logic [63:0] prod_ff;
   logic [64:0] prod_full;
   logic [63:0] rate, rate_a;

   assign prod_full = step_ff * r2;

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_full[63:0];
         d1_p_ff <= d1_r;
      end
   end

   adam_div #(.QUO_BITS(QB), .DIV_BITS(33)) u_rdiv (
      .clock   (clock),
      .en      (adv),
      .hi_in   (33'd0),
      .lo_in   (prod_ff),
      .den_in  (d1_p_ff),
      .quo_out (rate)
   );

   adam_delay #(.WIDTH(64), .DEPTH(TA - TR)) u_rate_dly (
      .clock (clock),
      .en    (adv),
      .din   (rate),
      .dout  (rate_a)
   );

   // delta = rate * q / 2^32: partials, then sum and saturate
   logic [63:0]  rq_ll_ff, rq_lh_ff, rq_hl_ff, rq_hh_ff, delta_ff;
   logic [127:0] rq_sum;

   always_ff @(posedge clock) begin
      if (adv) begin
         rq_ll_ff <= rate_a[31:0] * quo_a[31:0];
         rq_lh_ff <= rate_a[31:0] * quo_a[63:32];
         rq_hl_ff <= rate_a[63:32] * quo_a[31:0];
         rq_hh_ff <= rate_a[63:32] * quo_a[63:32];
      end
   end

   assign rq_sum = 128'(rq_ll_ff) + (128'(rq_lh_ff) << 32) + (128'(rq_hl_ff) << 32)
                 + (128'(rq_hh_ff) << 64);

   always_ff @(posedge clock) begin
      if (adv) begin
         delta_ff <= (rq_sum[127:96] != 32'd0) ? '1 : rq_sum[95:32];
      end
   end

   // side data carried to the update stage
   logic [VB-1:0] w_d, mn_d, vn_d;
   logic          mneg_d;

   adam_delay #(.WIDTH(VB), .DEPTH(TA + 2)) u_w_dly (
      .clock (clock),
      .en    (adv),
      .din   (in_ff.weight_value),
      .dout  (w_d)
   );

   adam_delay #(.WIDTH(VB), .DEPTH(TA - 2)) u_mn_dly (
      .clock (clock),
      .en    (adv),
      .din   (mn4_ff),
      .dout  (mn_d)
   );

   adam_delay #(.WIDTH(1), .DEPTH(TA - 2)) u_neg_dly (
      .clock (clock),
      .en    (adv),
      .din   (mn4_ff[VB-1]),
      .dout  (mneg_d)
   );

   adam_delay #(.WIDTH(VB), .DEPTH(TA - 4)) u_vn_dly (
      .clock (clock),
      .en    (adv),
      .din   (vn6_ff),
      .dout  (vn_d)
   );

   // weight update: step against the sign of the new first moment, saturate at the field range
   logic signed [65:0] w_x, room, w_up, w_dn;
   logic               over;
   logic [VB-1:0]      wn;
   rsp_type            rsp_ff;

   always_comb begin
      w_x  = 66'($signed(w_d));
      room = mneg_d ? (W_TOP - w_x) : (w_x - W_BOT);
      over = ({2'b0, delta_ff} > $unsigned(room));
      w_up = w_x + $signed({2'b0, delta_ff});
      w_dn = w_x - $signed({2'b0, delta_ff});
      if (mneg_d) begin
         wn = over ? W_TOP[VB-1:0] : w_up[VB-1:0];
      end else begin
         wn = over ? W_BOT[VB-1:0] : w_dn[VB-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff.new_weight        <= wn;
         rsp_ff.new_first_moment  <= mn_d;
         rsp_ff.new_second_moment <= vn_d;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== test/adam_optimizer_update_tb.sv =====
`timescale 1ns / 1ps
// Testbench for adam_optimizer_update: drives weight elements, predicts each Adam
// step in fixed point and checks every response beat. Depends on adam_pkg and the RTL.
module adam_optimizer_update_tb;
   import adam_pkg::*;

   localparam int LATENCY = 124;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = CSR_STEP_SIZE;
   logic [31:0] csr_wdata = '0;

   // predictor copy of the registers
   logic [63:0] lr_q, b1_q, b2_q, eps_q;

   req_type pending_beats[$];
   rsp_type expected_updates[$];
   int mismatches = 0;
   int hold_cycles = 0;
   bit long_hold_req = 1'b0;
   bit stim_done = 1'b0;

   adam_optimizer_update u_dut (.*);

   always #5 clock = ~clock;

   // ---------------- arithmetic helpers ----------------
   function automatic logic [63:0] mul_q32_sat(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      if (p[127:96] != 0) return '1;
      return p[95:32];
   endfunction

   // floor(x*c/2^32), signed x, c <= 2^32
   function automatic logic signed [63:0] smul_q32(logic signed [63:0] x, logic [63:0] c);
      logic signed [127:0] p;
      p = $signed({{64{x[63]}}, x}) * $signed({64'd0, c});
      return 64'(p >>> 32);
   endfunction

   function automatic logic [63:0] isqrt(logic [127:0] n);
      logic [63:0] res, cand;
      res = 0;
      for (int i = 63; i >= 0; i--) begin
         cand = res | (64'd1 << i);
         if ({64'd0, cand} * {64'd0, cand} <= n) res = cand;
      end
      return res;
   endfunction

   function automatic logic [63:0] pow_q32(logic [63:0] base, logic [63:0] t);
      logic [63:0] p;
      p = 64'd1 << 32;
      for (int i = 0; i <= COUNT_BITS; i++) begin
         if (t[i]) p = mul_q32_sat(p, base);
         base = mul_q32_sat(base, base);
      end
      return p;
   endfunction

   function automatic rsp_type adam_step(req_type r);
      logic signed [63:0] w, g, m, mn, s, wn, top, bot;
      logic signed [64:0] sum;
      logic [63:0] v, t, gmag, g2, v1, v2, vn, d1, d2, r2, rate, den, mmag, q, delta, room;
      logic [127:0] num, p, quo_full;
      rsp_type o;
      w = r.weight_value;
      g = r.gradient_value;
      m = r.first_moment;
      v = {16'd0, r.second_moment};
      t = {44'd0, r.update_count} + 64'd1;
      top = (64'sd1 <<< (VALUE_BITS - 1)) - 1;
      bot = -top - 1;
      // first moment
      sum = 65'(smul_q32(m, b1_q)) + 65'(smul_q32(g, (64'd1 << 32) - b1_q));
      if (sum > top) mn = top;
      else if (sum < bot) mn = bot;
      else mn = sum[63:0];
      // second moment
      gmag = g < 0 ? -g : g;
      g2 = mul_q32_sat(gmag, gmag);
      v1 = mul_q32_sat(v, b2_q);
      v2 = mul_q32_sat(g2, (64'd1 << 32) - b2_q);
      vn = (v1 > ~v2) ? '1 : v1 + v2;
      if (vn > 64'hFFFF_FFFF_FFFF) vn = 64'hFFFF_FFFF_FFFF;
      // bias-corrected rate
      d1 = (64'd1 << 32) - pow_q32(b1_q, t);
      d2 = (64'd1 << 32) - pow_q32(b2_q, t);
      r2 = isqrt({32'd0, d2, 32'd0});
      rate = (lr_q * r2) / d1;
      den = isqrt({32'd0, vn, 32'd0}) + eps_q;
      if (den == 0) den = 1;
      mmag = mn < 0 ? -mn : mn;
      num = {32'd0, mmag, 32'd0};
      quo_full = num / {64'd0, den};
      q = (quo_full > 128'hFFFF_FFFF_FFFF_FFFF) ? '1 : quo_full[63:0];
      p = {64'd0, rate} * {64'd0, q};
      delta = (p[127:96] != 0) ? '1 : p[95:32];
      if (mn < 0) begin
         room = top - w;
         wn = (delta > room) ? top : w + delta;
      end else begin
         room = w - bot;
         wn = (delta > room) ? bot : w - delta;
      end
      o.new_weight = wn[VALUE_BITS-1:0];
      o.new_first_moment = mn[VALUE_BITS-1:0];
      o.new_second_moment = vn[VALUE_BITS-1:0];
      return o;
   endfunction

   // no gap half the time, mostly short gaps otherwise, a few long ones
   function automatic int pick_gap();
      int k;
      k = $urandom_range(0, 99);
      if (k < 50) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [47:0] rand_val();
      case ($urandom_range(0, 5))
         0: return 48'h7FFF_FFFF_FFFF;
         1: return 48'h8000_0000_0000;
         2: return 48'({$urandom, $urandom} >> $urandom_range(0, 47));
         3: return -({16'd0, $urandom} >> $urandom_range(0, 31));
         default: return 48'({$urandom, $urandom});
      endcase
   endfunction

   function automatic req_type rand_beat(bit realistic);
      req_type r;
      r.weight_value = rand_val();
      r.gradient_value = rand_val();
      r.first_moment = rand_val();
      r.second_moment = rand_val();
      r.update_count = $urandom_range(0, 3) == 0 ? 20'hFFFFF
                                                 : 20'($urandom_range(0, 1000));
      if (realistic) begin
         // typical magnitudes around one, small moments
         r.weight_value = 48'($signed({$urandom}) >>> $urandom_range(0, 8));
         r.gradient_value = 48'($signed({$urandom}) >>> $urandom_range(0, 12));
         r.first_moment = 48'($signed({$urandom}) >>> $urandom_range(0, 12));
         r.second_moment = 48'($urandom >> $urandom_range(0, 20));
         r.update_count = 20'($urandom_range(0, 50));
      end
      return r;
   endfunction

   // append one beat to the stimulus queue
   task automatic queue_beat(req_type b);
      pending_beats = {pending_beats, b};
   endtask

   // ---------------- driver ----------------
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
         // hold
      end else begin
         if (req_valid) begin
            expected_updates = {expected_updates, adam_step(req_data)};
            req_gap = pick_gap();
         end
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            req_data <= pending_beats.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------- monitor ----------------
   int rsp_gap = 0;
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_updates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %p", rsp_data);
         end else begin
            exp_r = expected_updates.pop_front();
            if (rsp_data.new_weight !== exp_r.new_weight
                || rsp_data.new_first_moment !== exp_r.new_first_moment
                || rsp_data.new_second_moment !== exp_r.new_second_moment) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected w=%h m=%h v=%h got w=%h m=%h v=%h",
                           exp_r.new_weight, exp_r.new_first_moment,
                           exp_r.new_second_moment, rsp_data.new_weight,
                           rsp_data.new_first_moment, rsp_data.new_second_moment);
            end
         end
      end
      // receiver readiness; a long hold-off when requested
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_cycles = 400;
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_gap = pick_gap();
      end
   end

   task automatic drain();
      while (pending_beats.size() > 0 || req_valid || expected_updates.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_STEP_SIZE:    lr_q = 64'(val);
         CSR_DECAY_FIRST:  b1_q = 64'(val);
         CSR_DECAY_SECOND: b2_q = 64'(val);
         default:          eps_q = 64'(val);
      endcase
   endtask

   // ---------------- stimulus ----------------
   initial begin
      req_type r;
      lr_q = 64'(STEP_SIZE_RST);
      b1_q = 64'(DECAY_FIRST_RST);
      b2_q = 64'(DECAY_SECOND_RST);
      eps_q = 64'(EPSILON_RST);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, count at maximum, saturation
      r = '0;
      queue_beat(r);
      r.update_count = '1;
      queue_beat(r);
      r = '{48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
            48'hFFFF_FFFF_FFFF, 20'hFFFFF};
      queue_beat(r);
      r = '{48'h8000_0000_0000, 48'h8000_0000_0000, 48'h8000_0000_0000,
            48'h0, 20'h0};
      queue_beat(r);
      r = '{48'h8000_0000_0000, 48'h0, 48'h7FFF_FFFF_FFFF, 48'h0, 20'h0};
      queue_beat(r);
      r = '{48'h7FFF_FFFF_FFFF, 48'h0, 48'h8000_0000_0000, 48'h0, 20'h1};
      queue_beat(r);
      for (int i = 0; i < 6; i++) queue_beat(rand_beat(1'b1));
      drain();

      // zero epsilon: zero moments give a zero denominator
      csr_write(CSR_EPSILON, 32'd0);
      r = '0;
      queue_beat(r);
      r.first_moment = 48'h1_0000_0000;
      queue_beat(r);
      drain();

      // extremes of every register: zero decays, full step, max values
      csr_write(CSR_STEP_SIZE, 32'hFFFF_FFFF);
      csr_write(CSR_DECAY_FIRST, 32'd0);
      csr_write(CSR_DECAY_SECOND, 32'd0);
      csr_write(CSR_EPSILON, 32'hFFFF_FFFF);
      for (int i = 0; i < 60; i++) queue_beat(rand_beat(i % 4 != 0));
      drain();

      csr_write(CSR_DECAY_FIRST, 32'hFFFF_FFFF);
      csr_write(CSR_DECAY_SECOND, 32'hFFFF_FFFF);
      csr_write(CSR_STEP_SIZE, 32'd0);
      csr_write(CSR_EPSILON, 32'd1);
      for (int i = 0; i < 60; i++) queue_beat(rand_beat(i % 4 != 0));
      drain();

      // random register setting
      csr_write(CSR_STEP_SIZE, $urandom);
      csr_write(CSR_DECAY_FIRST, $urandom);
      csr_write(CSR_DECAY_SECOND, $urandom);
      csr_write(CSR_EPSILON, $urandom);
      for (int i = 0; i < 90; i++) queue_beat(rand_beat(i % 3 != 0));
      drain();

      // back to defaults; long receiver stall while the sender keeps offering
      csr_write(CSR_STEP_SIZE, STEP_SIZE_RST);
      csr_write(CSR_DECAY_FIRST, DECAY_FIRST_RST);
      csr_write(CSR_DECAY_SECOND, DECAY_SECOND_RST);
      csr_write(CSR_EPSILON, EPSILON_RST);
      for (int i = 0; i < 220; i++) queue_beat(rand_beat(i % 4 != 0));
      long_hold_req = 1'b1;
      drain();

      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sim.f =====
design/adam_pkg.sv
design/adam_delay.sv
design/adam_pow.sv
design/adam_sqrt.sv
design/adam_div.sv
design/adam_optimizer_update.sv
test/adam_optimizer_update_tb.sv
